[hw/rtl/lvpma_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvpma_pkg
// Shared widths, constants and the controller command word for the level
// percent moving average block.
// ----------------------------------------------------------------------------
package lvpma_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int REG_W     = 13;
	localparam int PCT_W     = 7;
	localparam int CFG_IDX_W = 1;

	// divider: 21-bit dividend, 13-bit divisor, 7 quotient bits
	localparam int REM_W     = 21;
	localparam int DIV_W     = REG_W;
	localparam int Q_W       = PCT_W;
	localparam int DIV_STEPS = Q_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam int PCT_MAX_N = 100;

	localparam logic [REG_W-1:0] FULL_SCALE     = 13'd4096;
	localparam logic [REG_W-1:0] RANGE_LOW_RST  = 13'd0;
	localparam logic [REG_W-1:0] RANGE_HIGH_RST = 13'd4095;
	localparam logic [PCT_W-1:0] PCT_MAX        = 7'd100;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'd1;

	typedef struct packed {
		logic load_sample;
		logic prep;
		logic div_step;
		logic div_first;
		logic commit;
		logic out_load;
	} lvpma_cmd_t;

endpackage

[hw/rtl/level_percent_moving_average.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_percent_moving_average
// Inverts a 12-bit sensor reading, rescales it to 0..100 percent between two
// configured bounds, and averages the last WINDOW_DEPTH percentages.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    adc_sample
//  out      out_valid/out_ready  level_percent, sample_percent
//  cfg      cfg_we               cfg_index, cfg_data
//
// a word passes through accept, a setup step, seven divider steps for the
// rescale, a commit step and a hand-off step; the divider yields one
// quotient bit per cycle. the window average is a reciprocal multiply.
// reset clears ring total and write slot, presets range registers; no sweep.
// a new word is accepted while the previous result waits in the output
// register; the hand-off cycle stalls only while that register is still full.
// ----------------------------------------------------------------------------
module level_percent_moving_average #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [lvpma_pkg::SAMPLE_W-1:0]   adc_sample,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lvpma_pkg::PCT_W-1:0]      level_percent,
	output logic [lvpma_pkg::PCT_W-1:0]      sample_percent,
	input  logic                             cfg_we,
	input  logic [lvpma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lvpma_pkg::REG_W-1:0]      cfg_data
);
	import lvpma_pkg::*;

	lvpma_cmd_t cmd;

	lvpma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	lvpma_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.adc_sample     (adc_sample),
		.level_percent  (level_percent),
		.sample_percent (sample_percent)
	);

endmodule

[hw/rtl/lvpma_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvpma_div
// Restoring divider, one quotient bit per step, seven steps. Flags overflow
// when the quotient would not fit in seven bits.
// ----------------------------------------------------------------------------
module lvpma_div (
	input  logic                          clk,
	input  logic                          load,
	input  logic                          step,
	input  logic                          first,
	input  logic [lvpma_pkg::REM_W-1:0]   dividend,
	input  logic [lvpma_pkg::DIV_W-1:0]   divisor,
	output logic [lvpma_pkg::Q_W-1:0]     quot,
	output logic                          ovf
);
	import lvpma_pkg::*;

	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] dsh_q;
	logic [Q_W-1:0]   quot_q;
	logic             ovf_q;
	logic             fits;

	assign fits = rem_q >= dsh_q;

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= dividend;
			dsh_q  <= REM_W'(divisor) << (DIV_STEPS - 1);
			quot_q <= '0;
		end else if (step) begin
			// quotient of 128 or more cannot be held
			if (first) begin
				ovf_q <= {1'b0, rem_q} >= {dsh_q, 1'b0};
			end
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[Q_W-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign quot = quot_q;
	assign ovf  = ovf_q;

endmodule

[hw/rtl/lvpma_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvpma_dp
// Datapath: range registers, inversion and rescale, clamp, reading ring with
// running total, and the output word register.
// ----------------------------------------------------------------------------
module lvpma_dp #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lvpma_pkg::lvpma_cmd_t            cmd,
	input  logic                             cfg_we,
	input  logic [lvpma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lvpma_pkg::REG_W-1:0]      cfg_data,
	input  logic [lvpma_pkg::SAMPLE_W-1:0]   adc_sample,
	output logic [lvpma_pkg::PCT_W-1:0]      level_percent,
	output logic [lvpma_pkg::PCT_W-1:0]      sample_percent
);
	import lvpma_pkg::*;

	localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int TOT_W  = $clog2(PCT_MAX_N * WINDOW_DEPTH + 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

	// window average as a multiply by a rounded-up reciprocal, exact for
	// every total below 2**TOT_W since 2**SLOT_W covers the depth
	localparam int AVG_SHIFT = TOT_W + SLOT_W;
	localparam int AVG_MUL_N = ((1 << AVG_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
	localparam int AVG_MUL_W = AVG_SHIFT + 1;
	localparam int PROD_W    = TOT_W + AVG_MUL_W;
	localparam logic [AVG_MUL_W-1:0] AVG_MUL = AVG_MUL_W'(AVG_MUL_N);

	logic [REG_W-1:0]    range_low_q;
	logic [REG_W-1:0]    range_high_q;
	logic [SAMPLE_W-1:0] sample_q;

	logic [PCT_W-1:0]    ring [WINDOW_DEPTH];
	logic [PCT_W-1:0]    old_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                wrapped_q;
	logic [TOT_W-1:0]    total_q;
	logic [PCT_W-1:0]    pct_q;
	logic                zero_q;
	logic [PCT_W-1:0]    level_q;
	logic [PCT_W-1:0]    sample_pct_q;

	logic [REG_W-1:0]        inv;
	logic signed [REG_W:0]   diff;
	logic signed [REG_W:0]   den;
	logic signed [REM_W-1:0] num;
	logic [REM_W-1:0]        num_abs;
	logic [DIV_W-1:0]        den_abs;
	logic                    zero_case;

	logic [PCT_W-1:0]  old_eff;
	logic [PCT_W-1:0]  pct_now;
	logic [TOT_W-1:0]  total_next;
	logic [PROD_W-1:0] avg_prod;
	logic [PCT_W-1:0]  avg_now;

	logic              div_load;
	logic [REM_W-1:0]  div_dividend;
	logic [DIV_W-1:0]  div_divisor;
	logic [Q_W-1:0]    quot;
	logic              ovf;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= RANGE_LOW_RST;
			range_high_q <= RANGE_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANGE_LOW:  range_low_q  <= cfg_data;
				REG_RANGE_HIGH: range_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			sample_q <= adc_sample;
		end
	end

	// inversion and signed rescale operands
	always_comb begin
		inv       = FULL_SCALE - REG_W'(sample_q);
		diff      = $signed({1'b0, inv}) - $signed({1'b0, range_low_q});
		den       = $signed({1'b0, range_high_q}) - $signed({1'b0, range_low_q});
		num       = $signed(REM_W'(diff)) * $signed(REM_W'(PCT_MAX));
		num_abs   = num[REM_W-1] ? REM_W'(-num) : REM_W'(num);
		den_abs   = den[REG_W] ? DIV_W'(-den) : DIV_W'(den);
		// equal bounds, or a quotient that can only be zero or negative
		zero_case = (den == '0) || (num[REM_W-1] != den[REG_W]);
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			zero_q <= zero_case;
		end
	end

	// clamp to 0..100
	always_comb begin
		if (zero_q) begin
			pct_now = '0;
		end else if (ovf || quot > PCT_MAX) begin
			pct_now = PCT_MAX;
		end else begin
			pct_now = quot;
		end
	end

	// ring entry never written reads as zero until the first wrap
	assign old_eff    = wrapped_q ? old_q : '0;
	assign total_next = total_q - TOT_W'(old_eff) + TOT_W'(pct_now);

	assign avg_prod = PROD_W'(total_q) * PROD_W'(AVG_MUL);
	assign avg_now  = avg_prod[AVG_SHIFT +: PCT_W];

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			old_q <= ring[slot_q];
		end
		if (cmd.commit) begin
			ring[slot_q] <= pct_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			wrapped_q <= 1'b0;
			total_q   <= '0;
		end else if (cmd.commit) begin
			total_q <= total_next;
			if (slot_q == LAST_SLOT) begin
				slot_q    <= '0;
				wrapped_q <= 1'b1;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			pct_q <= pct_now;
		end
		if (cmd.out_load) begin
			level_q      <= avg_now;
			sample_pct_q <= pct_q;
		end
	end

	// divider runs the rescale only
	assign div_load     = cmd.prep;
	assign div_dividend = num_abs;
	assign div_divisor  = den_abs;

	lvpma_div u_div (
		.clk      (clk),
		.load     (div_load),
		.step     (cmd.div_step),
		.first    (cmd.div_first),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quot     (quot),
		.ovf      (ovf)
	);

	assign level_percent  = level_q;
	assign sample_percent = sample_pct_q;

endmodule

[hw/rtl/lvpma_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvpma_ctrl
// Sequencer: accepts a word, runs the rescale through the divider, commits
// it to the window and hands the result to the output register.
// ----------------------------------------------------------------------------
module lvpma_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output lvpma_pkg::lvpma_cmd_t cmd
);
	import lvpma_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_DIV1 = 3'd2;
	localparam logic [2:0] S_PCT  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_sample = 1'b1;
					state_d         = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				cnt_d    = '0;
				state_d  = S_DIV1;
			end
			S_DIV1: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (cnt_q == '0);
				if (cnt_q == LAST_STEP) begin
					cnt_d   = '0;
					state_d = S_PCT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_PCT: begin
				cmd.commit = 1'b1;
				cnt_d      = '0;
				state_d    = S_FIN;
			end
			S_FIN: begin
				// wait for the output register to be free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

[verif/lvpma_level_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvpma_level_checker
// Watches the sample, result and register ports of the level percent moving
// average block, predicts each result from its own copy of the range
// registers and the averaging window, and compares results in order.
// ----------------------------------------------------------------------------
module lvpma_level_checker #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic [lvpma_pkg::SAMPLE_W-1:0]   adc_sample,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [lvpma_pkg::PCT_W-1:0]      level_percent,
	input  logic [lvpma_pkg::PCT_W-1:0]      sample_percent,
	input  logic                             cfg_we,
	input  logic [lvpma_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lvpma_pkg::REG_W-1:0]      cfg_data,
	output int                               mismatches,
	output int                               outstanding
);
	import lvpma_pkg::*;

	typedef struct {
		logic [PCT_W-1:0] level;
		logic [PCT_W-1:0] sample;
	} percent_pair_t;

	logic [REG_W-1:0] span_low;
	logic [REG_W-1:0] span_high;
	logic [PCT_W-1:0] window_ring [WINDOW_DEPTH];
	int               ring_slot;
	int               ring_sum;
	percent_pair_t    expected_percents [$];

	// inverted reading rescaled between the bounds, signed, truncated, clamped
	function automatic logic [PCT_W-1:0] rescale_percent(logic [SAMPLE_W-1:0] s,
			logic [REG_W-1:0] lo, logic [REG_W-1:0] hi);
		int inv;
		int span;
		int q;
		inv = int'(FULL_SCALE) - int'(s);
		span = int'(hi) - int'(lo);
		if (span == 0)
			return '0;
		q = ((inv - int'(lo)) * PCT_MAX_N) / span;
		if (q < 0)
			q = 0;
		if (q > PCT_MAX_N)
			q = PCT_MAX_N;
		return PCT_W'(q);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		percent_pair_t want;
		logic [PCT_W-1:0] pct;
		if (!arst_n) begin
			span_low = RANGE_LOW_RST;
			span_high = RANGE_HIGH_RST;
			for (int i = 0; i < WINDOW_DEPTH; i++)
				window_ring[i] = '0;
			ring_slot = 0;
			ring_sum = 0;
			expected_percents.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_RANGE_LOW: span_low = cfg_data;
					REG_RANGE_HIGH: span_high = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				pct = rescale_percent(adc_sample, span_low, span_high);
				ring_sum = ring_sum - int'(window_ring[ring_slot]) + int'(pct);
				window_ring[ring_slot] = pct;
				ring_slot = (ring_slot + 1) % WINDOW_DEPTH;
				want.level = PCT_W'(ring_sum / WINDOW_DEPTH);
				want.sample = pct;
				expected_percents.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (expected_percents.size() == 0) begin
					mismatches++;
					$display("%0t: result word with nothing outstanding: level %0d sample %0d",
						$time, level_percent, sample_percent);
				end else begin
					want = expected_percents.pop_front();
					if (level_percent !== want.level) begin
						mismatches++;
						$display("%0t: level_percent expected %0d actual %0d",
							$time, want.level, level_percent);
					end
					if (sample_percent !== want.sample) begin
						mismatches++;
						$display("%0t: sample_percent expected %0d actual %0d",
							$time, want.sample, sample_percent);
					end
				end
			end
		end
		outstanding = expected_percents.size();
	end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives level sensor samples and range settings into the level percent
// moving average block under random back-pressure and gaps; the checker
// beside it predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;
	import lvpma_pkg::*;

	localparam int WINDOW_DEPTH = 16;
	localparam int N_PHASES     = 12;
	localparam int PHASE_WORDS  = 58;
	localparam int SETTLE       = 24;
	localparam int LONG_HOLD    = 300;

	typedef enum {RANGE_FIXED, RANGE_REALISTIC, RANGE_ANY} range_pick_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [SAMPLE_W-1:0]  adc_sample;
	logic                 out_valid;
	logic                 out_ready;
	logic [PCT_W-1:0]     level_percent;
	logic [PCT_W-1:0]     sample_percent;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;
	int                   mismatches;
	int                   outstanding;

	logic                 steady;
	// toggled by the sender to ask the receiver for one long hold-off
	logic                 hold_off_req;

	// phase table: bounds, how they are picked, and whether idling is off
	int          phase_low   [N_PHASES] = '{0, 512, 1234, 3000, 0, 8191, 4096, 0, 0, 0, 100, 0};
	int          phase_high  [N_PHASES] = '{4095, 3584, 1234, 1000, 8191, 0, 1, 0, 0, 4096,
		200, 0};
	range_pick_t phase_pick  [N_PHASES] = '{RANGE_FIXED, RANGE_FIXED, RANGE_FIXED, RANGE_FIXED,
		RANGE_FIXED, RANGE_FIXED, RANGE_FIXED, RANGE_REALISTIC, RANGE_ANY, RANGE_FIXED,
		RANGE_FIXED, RANGE_REALISTIC};
	bit          phase_steady [N_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0};

	logic [SAMPLE_W-1:0] directed_samples [12] = '{12'd0, 12'd4095, 12'd1, 12'd4094, 12'd2048,
		12'h555, 12'hAAA, 12'h800, 12'h7FF, 12'd4095, 12'd0, 12'd1024};

	level_percent_moving_average #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.adc_sample(adc_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.level_percent(level_percent),
		.sample_percent(sample_percent),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	lvpma_level_checker #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) level_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.adc_sample(adc_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.level_percent(level_percent),
		.sample_percent(sample_percent),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	// often readings whose inverse lands near the configured bounds, else extremes or random readings
	function automatic logic [SAMPLE_W-1:0] pick_sample(int lo, int hi);
		int r;
		int a;
		int b;
		r = $urandom_range(0, 99);
		a = (lo < hi ? lo : hi) - 40;
		b = (lo < hi ? hi : lo) + 40;
		if (a < 1)
			a = 1;
		if (b > int'(FULL_SCALE))
			b = int'(FULL_SCALE);
		if (r < 10)
			return r[0] ? {SAMPLE_W{1'b1}} : '0;
		if (r < 55 && a <= b)
			return SAMPLE_W'(int'(FULL_SCALE) - $urandom_range(a, b));
		return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
	endfunction

	// enters and leaves at a falling edge; valid stays up for back-to-back words
	task automatic send_sample(logic [SAMPLE_W-1:0] s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic program_range(int lo, int hi);
		cfg_we <= 1'b1;
		cfg_index <= REG_RANGE_LOW;
		cfg_data <= REG_W'(lo);
		@(negedge clk);
		cfg_index <= REG_RANGE_HIGH;
		cfg_data <= REG_W'(hi);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// receiver: bursts of ready and stalls, plus the long hold-off on request
	initial begin
		int r;
		int span;
		logic hold_seen;
		hold_seen = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_req != hold_seen) begin
				hold_seen = hold_off_req;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else if (steady) begin
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					out_ready <= 1'b1;
					span = $urandom_range(1, 20);
				end else begin
					out_ready <= 1'b0;
					span = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
				end
				repeat (span - 1) @(negedge clk);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int lo;
		int hi;
		in_valid = 1'b0;
		adc_sample = '0;
		cfg_we = 1'b0;
		cfg_index = REG_RANGE_LOW;
		cfg_data = '0;
		steady = 1'b0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset bounds and extremes of the reading, within a window not yet full
		foreach (directed_samples[i])
			send_sample(directed_samples[i]);
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			case (phase_pick[p])
				RANGE_REALISTIC: begin
					lo = $urandom_range(0, 3000);
					hi = $urandom_range(lo + 1, int'(FULL_SCALE));
				end
				RANGE_ANY: begin
					lo = $urandom_range(0, (1 << REG_W) - 1);
					hi = $urandom_range(0, (1 << REG_W) - 1);
				end
				default: begin
					lo = phase_low[p];
					hi = phase_high[p];
				end
			endcase
			program_range(lo, hi);
			steady = phase_steady[p];
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (p == 1 && n == 20)
					hold_off_req = ~hold_off_req;
				if (p == 3 && n == 30) begin
					in_valid <= 1'b0;
					wait (outstanding == 0);
					@(negedge clk);
				end
				send_sample(pick_sample(lo, hi));
			end
			drain();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
